// ===== rtl/core/llt_pkg.sv =====
// Shared constants, result and item types for the log line tokenizer.
// Used by the channel interfaces, the lexer, the result queue and the top level.
// No dependencies.
package llt_pkg;

  // Column and line counter widths.
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned LINE_BITS   = 24;
  localparam int unsigned BYTE_BITS   = 8;

  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  // One input byte causes at most this many results.
  localparam int unsigned MAX_RESULTS  = 4;
  localparam int unsigned RES_CNT_BITS = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_BITS = $clog2(MAX_RESULTS);

  // Result queue depth; must be a power of two so the pointers wrap on their own.
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_INT     = 3'd0,
    KIND_HEX     = 3'd1,
    KIND_BIN     = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_WORD    = 3'd4,
    KIND_PATH    = 3'd5,
    KIND_SPECIAL = 3'd6,
    KIND_EOL     = 3'd7
  } token_kind_e;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_input;
  } item_t;

  typedef struct packed {
    token_kind_e            kind;
    logic [COLUMN_BITS-1:0] start;
    logic [COLUMN_BITS-1:0] length;
    logic [LINE_BITS-1:0]   line;
    logic                   ovf;
    logic                   last;
  } result_t;

  // Results of one lexer step, in order; only the first count entries are meaningful.
  typedef struct packed {
    logic [RES_CNT_BITS-1:0]          count;
    result_t [MAX_RESULTS-1:0]        res;
  } push_t;

endpackage

// ===== rtl/core/llt_ifs.sv =====
// Valid/ready channel interfaces for raw input bytes and for token results.
// Depends on llt_pkg for field widths and the token kind type.

interface llt_in_if;
  logic                          valid;
  logic                          ready;
  logic [llt_pkg::BYTE_BITS-1:0] data_byte;
  logic                          end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

interface llt_out_if;
  logic                            valid;
  logic                            ready;
  llt_pkg::token_kind_e            token_kind;
  logic [llt_pkg::COLUMN_BITS-1:0] token_start;
  logic [llt_pkg::COLUMN_BITS-1:0] token_length;
  logic [llt_pkg::LINE_BITS-1:0]   line_number;
  logic                            column_overflow;
  logic                            last_of_run;

  modport source (output valid, token_kind, token_start, token_length, line_number,
                  column_overflow, last_of_run, input ready);
  modport sink   (input valid, token_kind, token_start, token_length, line_number,
                  column_overflow, last_of_run, output ready);
endinterface

// ===== rtl/core/llt_lexer.sv =====
// Byte filter, column and line counters and the token state machine.
// Processes one registered input byte per step and hands out up to four results.
// Depends on llt_pkg.
module llt_lexer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  llt_pkg::item_t  item_i,
  output llt_pkg::push_t  push_o
);

  localparam int unsigned COL_W   = llt_pkg::COLUMN_BITS;
  localparam int unsigned LINE_W  = llt_pkg::LINE_BITS;
  localparam int unsigned CNT_W   = llt_pkg::RES_CNT_BITS;
  localparam int unsigned IDX_W   = llt_pkg::RES_IDX_BITS;
  localparam int unsigned NRES    = llt_pkg::MAX_RESULTS;
  localparam int unsigned WIN     = 3;
  localparam int unsigned LEX_STEPS = 2 * WIN;

  localparam logic [7:0] CH_EOL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_INT  = 9'b000000010,
    ST_FRAC = 9'b000000100,
    ST_EXP  = 9'b000001000,
    ST_EXPD = 9'b000010000,
    ST_HEX  = 9'b000100000,
    ST_BIN  = 9'b001000000,
    ST_PATH = 9'b010000000,
    ST_WORD = 9'b100000000
  } lex_state_e;

  typedef enum logic [1:0] {
    ACT_NEED,
    ACT_SKIP,
    ACT_SPECIAL,
    ACT_START
  } act_e;

  typedef struct packed {
    act_e       act;
    lex_state_e st;
    logic       two;
  } decision_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_route(input logic [7:0] c);
    return is_alpha(c) || (c == ":") || (c == ".") || (c == "/") || (c == CH_BSLASH);
  endfunction

  // Next in-token state for character c, or ST_IDLE when the token ends here.
  function automatic lex_state_e advance(input lex_state_e st, input logic [7:0] c);
    lex_state_e nx;
    nx = ST_IDLE;
    case (st)
      ST_INT: begin
        if (is_dec(c)) nx = ST_INT;
        else if ((c == "e") || (c == "E")) nx = ST_EXP;
        else if (c == ".") nx = ST_FRAC;
      end
      ST_FRAC: begin
        if (is_dec(c)) nx = ST_FRAC;
        else if ((c == "e") || (c == "E")) nx = ST_EXP;
      end
      ST_EXP: begin
        if ((c == "+") || (c == "-") || is_dec(c)) nx = ST_EXPD;
      end
      ST_EXPD: if (is_dec(c)) nx = ST_EXPD;
      ST_HEX:  if (is_hex(c)) nx = ST_HEX;
      ST_BIN:  if ((c == "0") || (c == "1")) nx = ST_BIN;
      ST_PATH: if (is_route(c)) nx = ST_PATH;
      ST_WORD: if (is_alpha(c) || (c == "_")) nx = ST_WORD;
      default: nx = ST_IDLE;
    endcase
    return nx;
  endfunction

  function automatic llt_pkg::token_kind_e kind_of(input lex_state_e st);
    llt_pkg::token_kind_e k;
    case (st)
      ST_INT:  k = llt_pkg::KIND_INT;
      ST_HEX:  k = llt_pkg::KIND_HEX;
      ST_BIN:  k = llt_pkg::KIND_BIN;
      ST_FRAC, ST_EXP, ST_EXPD: k = llt_pkg::KIND_FLOAT;
      ST_WORD: k = llt_pkg::KIND_WORD;
      default: k = llt_pkg::KIND_PATH;
    endcase
    return k;
  endfunction

  // Token start decision with up to two characters of lookahead; v1/v2 flag
  // whether c1/c2 have been seen yet.
  function automatic decision_t decide(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic v1, input logic [7:0] c2,
                                       input logic v2);
    decision_t d;
    d.act = ACT_SPECIAL;
    d.st  = ST_IDLE;
    d.two = 1'b0;
    if ((c0 == CH_EOL) || (c0 == CH_SPACE)) begin
      d.act = ACT_SKIP;
    end else if (c0 == "0") begin
      if (!v1) begin
        d.act = ACT_NEED;
      end else if ((c1 == "x") && !v2) begin
        d.act = ACT_NEED;
      end else if ((c1 == "x") && is_hex(c2)) begin
        d.act = ACT_START; d.st = ST_HEX; d.two = 1'b1;
      end else if (c1 == "b") begin
        d.act = ACT_START; d.st = ST_BIN; d.two = 1'b1;
      end else begin
        d.act = ACT_START; d.st = ST_INT;
      end
    end else if (is_dec(c0)) begin
      d.act = ACT_START; d.st = ST_INT;
    end else if (c0 == "-") begin
      if (!v1) begin
        d.act = ACT_NEED;
      end else if (c1 == ".") begin
        if (!v2) begin
          d.act = ACT_NEED;
        end else if (is_dec(c2)) begin
          d.act = ACT_START; d.st = ST_FRAC; d.two = 1'b1;
        end
      end else if (is_dec(c1)) begin
        d.act = ACT_START; d.st = ST_INT;
      end
    end else if ((c0 == ".") || (c0 == "+")) begin
      if (!v1) begin
        d.act = ACT_NEED;
      end else if (is_dec(c1)) begin
        d.act = ACT_START; d.st = ST_INT;
      end
    end else if (c0 == "~") begin
      if (!v1) begin
        d.act = ACT_NEED;
      end else if (c1 == "/") begin
        d.act = ACT_START; d.st = ST_PATH;
      end
    end else if (c0 == "/") begin
      d.act = ACT_START; d.st = ST_PATH;
    end else if (is_alpha(c0)) begin
      if (!v1) begin
        d.act = ACT_NEED;
      end else if ((c1 == ":") && !v2) begin
        d.act = ACT_NEED;
      end else if ((c1 == ":") && ((c2 == "/") || (c2 == CH_BSLASH))) begin
        d.act = ACT_START; d.st = ST_PATH;
      end else begin
        d.act = ACT_START; d.st = ST_WORD;
      end
    end else if (c0 == "_") begin
      d.act = ACT_START; d.st = ST_WORD;
    end
    return d;
  endfunction

  // State registers
  lex_state_e          st_q, st_d;
  logic [COL_W-1:0]    tb_q, tb_d;
  logic [7:0]          la_q [2];
  logic [7:0]          la_d [2];
  logic [1:0]          lac_q, lac_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic                ovf_q, ovf_d;

  // Step logic
  logic [7:0]          raw;
  logic                is_nl, is_drop, is_char, end_line, col_full, ovf_now;
  logic [7:0]          take_c;
  logic [7:0]          wc [WIN];
  logic [COL_W-1:0]    wcol [WIN];
  logic [1:0]          m;
  logic [1:0]          i;
  logic                stop;
  lex_state_e          st, nx;
  logic [COL_W-1:0]    tb;
  logic [7:0]          la_n [2];
  logic [1:0]          lac_n;
  logic [7:0]          c1, c2;
  logic                v1, v2;
  decision_t           d;
  logic [CNT_W-1:0]    n_emit;
  llt_pkg::result_t [NRES-1:0] res;

  always_comb begin
    raw      = item_i.data_byte;
    is_nl    = (raw == CH_NL);
    is_drop  = (raw < CH_SPACE) || (raw == CH_DEL) || (raw[7:6] == 2'b10);
    is_char  = !item_i.end_of_input && !is_nl && !is_drop;
    end_line = (item_i.end_of_input && (col_q != '0)) || (!item_i.end_of_input && is_nl);
    col_full = (col_q == llt_pkg::COL_MAX);
    ovf_now  = ovf_q || (is_char && col_full);
    // A UTF-8 start byte stands as '?'; the end of a line enters as a zero character.
    take_c   = end_line ? CH_EOL : (raw[7] ? CH_QMARK : raw);

    // Window: pending lookahead bytes followed by the new character. The new
    // character's column is the current count, which already saturates.
    wc[0]   = la_q[0];
    wc[1]   = la_q[1];
    wc[2]   = take_c;
    wcol[0] = tb_q;
    wcol[1] = (tb_q == llt_pkg::COL_MAX) ? tb_q : tb_q + COL_W'(1);
    wcol[2] = col_q;
    if (lac_q == 2'd0) begin
      wc[0]   = take_c;
      wcol[0] = col_q;
    end else if (lac_q == 2'd1) begin
      wc[1]   = take_c;
      wcol[1] = col_q;
    end
    m = (lac_q >= 2'd2) ? 2'd3 : lac_q + 2'd1;

    st     = st_q;
    tb     = tb_q;
    la_n   = la_q;
    lac_n  = 2'd0;
    i      = 2'd0;
    stop   = 1'b0;
    n_emit = '0;
    res    = '0;
    nx     = ST_IDLE;
    c1     = '0;
    c2     = '0;
    v1     = 1'b0;
    v2     = 1'b0;
    d      = '0;

    // Each window character takes at most two steps: one that may end the
    // running token and one that decides the next token.
    for (int k = 0; k < LEX_STEPS; k++) begin
      if (!stop && (i < m)) begin
        if (st != ST_IDLE) begin
          nx = advance(st, wc[i]);
          if (nx != ST_IDLE) begin
            st = nx;
            i  = i + 2'd1;
          end else begin
            if (n_emit < CNT_W'(NRES)) begin
              res[n_emit[IDX_W-1:0]].kind   = kind_of(st);
              res[n_emit[IDX_W-1:0]].start  = tb;
              res[n_emit[IDX_W-1:0]].length = wcol[i] - tb;
              n_emit = n_emit + CNT_W'(1);
            end
            st = ST_IDLE;
          end
        end else begin
          v1 = ({1'b0, i} + 3'd1) < {1'b0, m};
          v2 = ({1'b0, i} + 3'd2) < {1'b0, m};
          c1 = (i == 2'd0) ? wc[1] : wc[2];
          c2 = wc[2];
          d  = decide(wc[i], c1, v1, c2, v2);
          case (d.act)
            ACT_NEED: begin
              tb      = wcol[i];
              la_n[0] = wc[i];
              la_n[1] = c1;
              lac_n   = v1 ? 2'd2 : 2'd1;
              stop    = 1'b1;
            end
            ACT_SKIP: begin
              i = i + 2'd1;
            end
            ACT_SPECIAL: begin
              if (n_emit < CNT_W'(NRES)) begin
                res[n_emit[IDX_W-1:0]].kind   = llt_pkg::KIND_SPECIAL;
                res[n_emit[IDX_W-1:0]].start  = wcol[i];
                res[n_emit[IDX_W-1:0]].length = COL_W'(1);
                n_emit = n_emit + CNT_W'(1);
              end
              i = i + 2'd1;
            end
            ACT_START: begin
              st = d.st;
              tb = wcol[i];
              i  = i + (d.two ? 2'd2 : 2'd1);
            end
            default: begin
              stop = 1'b1;
            end
          endcase
        end
      end
    end

    st_d   = st_q;
    tb_d   = tb_q;
    la_d   = la_q;
    lac_d  = lac_q;
    col_d  = col_q;
    line_d = line_q;
    ovf_d  = ovf_q;

    if (step_i && (is_char || end_line)) begin
      st_d  = st;
      tb_d  = tb;
      la_d  = la_n;
      lac_d = lac_n;
      ovf_d = ovf_now;
      if (is_char && !col_full) begin
        col_d = col_q + COL_W'(1);
      end
      if (end_line) begin
        if ((col_q != '0) && (n_emit < CNT_W'(NRES))) begin
          res[n_emit[IDX_W-1:0]].kind   = llt_pkg::KIND_EOL;
          res[n_emit[IDX_W-1:0]].start  = '0;
          res[n_emit[IDX_W-1:0]].length = col_q;
          n_emit = n_emit + CNT_W'(1);
        end
        st_d  = ST_IDLE;
        tb_d  = '0;
        lac_d = 2'd0;
        col_d = '0;
        ovf_d = 1'b0;
        if (line_q != llt_pkg::LINE_MAX) begin
          line_d = line_q + LINE_W'(1);
        end
      end
    end else begin
      n_emit = '0;
    end

    for (int k = 0; k < NRES; k++) begin
      res[k].line = line_q;
      res[k].ovf  = ovf_now;
      res[k].last = (CNT_W'(k + 1) == n_emit);
    end
    push_o.count = n_emit;
    push_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      tb_q   <= '0;
      lac_q  <= 2'd0;
      col_q  <= '0;
      line_q <= LINE_W'(1);
      ovf_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      tb_q   <= tb_d;
      lac_q  <= lac_d;
      col_q  <= col_d;
      line_q <= line_d;
      ovf_q  <= ovf_d;
    end
  end

  // Lookahead bytes only count under lac_q.
  always_ff @(posedge clk_i) begin
    la_q <= la_d;
  end

  a_la_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lac_q != 2'd0) |-> (st_q == ST_IDLE))
    else $error("lookahead pending while a token is open");

  a_empty_line_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q == '0) |-> ((st_q == ST_IDLE) && (lac_q == 2'd0)))
    else $error("lexer not at rest on an empty line");

  a_token_begin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> (tb_q <= col_q))
    else $error("open token starts beyond the current column");

endmodule

// ===== rtl/core/llt_result_fifo.sv =====
// Result queue: takes up to four results per cycle from the lexer, hands out one
// per transfer. Depends on llt_pkg.
module llt_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  llt_pkg::push_t   push_i,
  output logic             room_o,
  output logic             head_valid_o,
  output llt_pkg::result_t head_o,
  input  logic             pop_i
);

  localparam int unsigned DEPTH = llt_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = llt_pkg::FIFO_PTR_BITS;
  localparam int unsigned CNT_W = llt_pkg::FIFO_CNT_BITS;
  localparam int unsigned NRES  = llt_pkg::MAX_RESULTS;

  llt_pkg::result_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] push_cnt;

  assign push_cnt     = CNT_W'(push_i.count);
  // Room for a worst-case step, judged on the registered fill level.
  assign room_o       = (count_q <= CNT_W'(DEPTH - NRES));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + (pop_i ? PTR_W'(1) : '0);
    count_d  = count_q + push_cnt - (pop_i ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NRES; k++) begin
      if (CNT_W'(k) < push_cnt) begin
        mem_q[wr_ptr_q + PTR_W'(k)] <= push_i.res[k];
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt != '0) |-> ((count_q + push_cnt) <= CNT_W'(DEPTH)))
    else $error("result queue written beyond its depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("result queue read while empty");

  a_pop_only_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && (push_cnt == '0)) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("fill level wrong after a lone read");

endmodule

// ===== rtl/core/log_line_tokenizer_core.sv =====
// Log line tokenizer: splits a raw log byte stream into lines and tokens.
// Path: an accepted byte waits in the input register until the result queue has room,
// then the lexer processes it and its results are queued and sent out from the head.
// Throughput: one byte per cycle while the queue has room for a worst-case step; the
// output moves at most one result per cycle, so results that pile up hold the input back.
// Reset (asynchronous, active low): lexer idle, column zero, line one, queue empty.
module log_line_tokenizer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  llt_in_if.sink    in_i,
  llt_out_if.source out_o
);

  // The input register holds one byte. It is processed while the result queue has
  // room for the largest result burst a byte is allowed to cause (four results,
  // handed over in order in one step); until then it waits in the register.
  // A new byte is taken in the same cycle the held one is processed, so the input
  // side never waits on an output that is merely slow to take a single result.
  logic            in_valid_q;
  llt_pkg::item_t  item_q;
  logic            fifo_room;
  logic            step;
  llt_pkg::push_t  push;
  logic            head_valid;
  llt_pkg::result_t head;
  logic            pop;

  assign step     = in_valid_q && fifo_room;
  assign in_i.ready = !in_valid_q || fifo_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.data_byte    <= in_i.data_byte;
      item_q.end_of_input <= in_i.end_of_input;
    end
  end

  // The lexer filters the byte, moves the column and line counters and runs the
  // token state machine over its two-byte lookahead window plus the new byte. All
  // of the byte's results leave in one step, in order, with the last one flagged.
  llt_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .push_o (push)
  );

  // The result queue turns a burst of results into single transfers and parts the
  // output handshake from the input side.
  llt_result_fifo u_result_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (fifo_room),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  assign pop                   = head_valid && out_o.ready;
  assign out_o.valid           = head_valid;
  assign out_o.token_kind      = head.kind;
  assign out_o.token_start     = head.start;
  assign out_o.token_length    = head.length;
  assign out_o.line_number     = head.line;
  assign out_o.column_overflow = head.ovf;
  assign out_o.last_of_run     = head.last;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for log_line_tokenizer_core: random and directed byte streams.
// Depends on llt_pkg (token kinds, result type) and on the llt_in_if / llt_out_if channels.
// A built-in line lexer predicts every token; results are checked in order.
module tb_top;

  // The whole run must finish well inside this many cycles. The slowest legal run
  // has every byte idle for the longest wait and cause four results that each wait
  // the longest on the output.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int unsigned COL_TOP = llt_pkg::COL_MAX;
  localparam int MAX_REPORTS = 10;

  // Lexer states of the predictor, one per kind of token being collected.
  typedef enum logic [3:0] {
    LX_IDLE, LX_INT, LX_FRAC, LX_EXP, LX_EXPD, LX_HEX, LX_BIN, LX_PATH, LX_WORD
  } lex_e;

  // What happens at the first character of a possible token.
  typedef enum logic [2:0] {SD_WAIT, SD_SKIP, SD_SINGLE, SD_EOL, SD_TOKEN} start_e;

  typedef struct packed {
    start_e     act;
    lex_e       st;
    logic [1:0] used;
  } lead_t;

  // One byte of stimulus; burst means no idle cycles after its transfer.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       burst;
  } feed_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side copies of the block inputs, known from time zero.
  logic       tx_valid = 1'b0;
  logic [7:0] tx_byte = 8'h00;
  logic       tx_eoi = 1'b0;
  logic       rx_ready = 1'b0;

  llt_in_if  in_ch ();
  llt_out_if out_ch ();

  assign in_ch.valid        = tx_valid;
  assign in_ch.data_byte    = tx_byte;
  assign in_ch.end_of_input = tx_eoi;
  assign out_ch.ready       = rx_ready;

  log_line_tokenizer_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expected results.
  feed_item_t        feed_q[$];
  llt_pkg::result_t  expected_tokens[$];
  logic              line_burst = 1'b0;

  // Predictor state: mirrors the lexer, the lookahead window and the counters.
  lex_e                          lex_st = LX_IDLE;
  int                            pend_chr[2];
  int                            pend_cnt = 0;
  int unsigned                   tok_begin = 0;
  int unsigned                   col_cnt = 0;
  logic [llt_pkg::LINE_BITS-1:0] line_cnt = 1;
  logic                          ovf_seen = 1'b0;
  int                            step_n = 0;

  // Counters for checking and for the closing summary.
  int mismatch_count = 0;
  int bytes_moved = 0;
  int results_moved = 0;

  // ---------------------------------------------------------------------------
  // Character classes of the lexer.
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex(int c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_alpha(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_route(int c);
    return is_alpha(c) || c == ":" || c == "." || c == "/" || c == "\\";
  endfunction

  function automatic llt_pkg::token_kind_e kind_for(lex_e st);
    case (st)
      LX_INT:                   return llt_pkg::KIND_INT;
      LX_HEX:                   return llt_pkg::KIND_HEX;
      LX_BIN:                   return llt_pkg::KIND_BIN;
      LX_FRAC, LX_EXP, LX_EXPD: return llt_pkg::KIND_FLOAT;
      LX_WORD:                  return llt_pkg::KIND_WORD;
      default:                  return llt_pkg::KIND_PATH;
    endcase
  endfunction

  // Next state while inside a token; LX_IDLE means the character ends the token.
  function automatic lex_e next_state(lex_e st, int c);
    case (st)
      LX_INT: begin
        if (is_digit(c)) return LX_INT;
        if (c == "e" || c == "E") return LX_EXP;
        if (c == ".") return LX_FRAC;
        return LX_IDLE;
      end
      LX_FRAC: begin
        if (is_digit(c)) return LX_FRAC;
        if (c == "e" || c == "E") return LX_EXP;
        return LX_IDLE;
      end
      LX_EXP:  return (c == "+" || c == "-" || is_digit(c)) ? LX_EXPD : LX_IDLE;
      LX_EXPD: return is_digit(c) ? LX_EXPD : LX_IDLE;
      LX_HEX:  return is_hex(c) ? LX_HEX : LX_IDLE;
      LX_BIN:  return (c == "0" || c == "1") ? LX_BIN : LX_IDLE;
      LX_PATH: return is_route(c) ? LX_PATH : LX_IDLE;
      LX_WORD: return (is_alpha(c) || c == "_") ? LX_WORD : LX_IDLE;
      default: return LX_IDLE;
    endcase
  endfunction

  function automatic lead_t enter(lex_e st, int n);
    lead_t r;
    r.act  = SD_TOKEN;
    r.st   = st;
    r.used = n[1:0];
    return r;
  endfunction

  // Token start decision. c1 and c2 are -1 when not yet seen; 0 marks the line end.
  // Signs, dots, '~', a leading '0' and a letter followed by ':' need lookahead before the
  // kind is known; SD_WAIT parks them in the window until enough has arrived.
  function automatic lead_t classify_start(int c0, int c1, int c2);
    lead_t r;
    r.act  = SD_SINGLE;
    r.st   = LX_IDLE;
    r.used = 2'd1;
    if (c0 == 0) begin
      r.act = SD_EOL;
    end else if (c0 == " ") begin
      r.act = SD_SKIP;
    end else if (c0 == "0") begin
      if (c1 < 0 || (c1 == "x" && c2 < 0)) r.act = SD_WAIT;
      else if (c1 == "x" && is_hex(c2)) r = enter(LX_HEX, 2);
      else if (c1 == "b") r = enter(LX_BIN, 2);
      else r = enter(LX_INT, 1);
    end else if (is_digit(c0)) begin
      r = enter(LX_INT, 1);
    end else if (c0 == "-") begin
      if (c1 < 0) r.act = SD_WAIT;
      else if (c1 == ".") begin
        if (c2 < 0) r.act = SD_WAIT;
        else if (is_digit(c2)) r = enter(LX_FRAC, 2);
      end else if (is_digit(c1)) r = enter(LX_INT, 1);
    end else if (c0 == "." || c0 == "+") begin
      if (c1 < 0) r.act = SD_WAIT;
      else if (is_digit(c1)) r = enter(LX_INT, 1);
    end else if (c0 == "~") begin
      if (c1 < 0) r.act = SD_WAIT;
      else if (c1 == "/") r = enter(LX_PATH, 1);
    end else if (c0 == "/") begin
      r = enter(LX_PATH, 1);
    end else if (is_alpha(c0)) begin
      if (c1 < 0 || (c1 == ":" && c2 < 0)) r.act = SD_WAIT;
      else if (c1 == ":" && (c2 == "/" || c2 == "\\")) r = enter(LX_PATH, 1);
      else r = enter(LX_WORD, 1);
    end else if (c0 == "_") begin
      r = enter(LX_WORD, 1);
    end
    return r;
  endfunction

  // Queues one expected result; a single byte never causes more than MAX_RESULTS.
  function automatic void push_token(llt_pkg::token_kind_e kind, int unsigned start,
                                     int unsigned len);
    llt_pkg::result_t r;
    if (step_n >= llt_pkg::MAX_RESULTS) return;
    r.kind   = kind;
    r.start  = start[llt_pkg::COLUMN_BITS-1:0];
    r.length = len[llt_pkg::COLUMN_BITS-1:0];
    r.line   = line_cnt;
    r.ovf    = ovf_seen;
    r.last   = 1'b0;
    expected_tokens.push_back(r);
    step_n++;
  endfunction

  // Runs the parked lookahead characters plus one new character through the lexer.
  function automatic void scan_chars(int c, int unsigned col);
    int          wc[3];
    int unsigned wcol[3];
    int          m;
    int          i;
    int          j;
    int          c1;
    int          c2;
    lex_e        nx;
    lead_t       d;
    m = 0;
    i = 0;
    // Parked characters sit at consecutive columns from the token start, which
    // saturate like every other column.
    for (j = 0; j < pend_cnt; j++) begin
      wc[m]   = pend_chr[j];
      wcol[m] = (tok_begin + j > COL_TOP) ? COL_TOP : tok_begin + j;
      m++;
    end
    wc[m]   = c;
    wcol[m] = col;
    m++;
    pend_cnt = 0;
    while (i < m) begin
      if (lex_st != LX_IDLE) begin
        nx = next_state(lex_st, wc[i]);
        if (nx != LX_IDLE) begin
          lex_st = nx;
          i++;
        end else begin
          // The ending character is looked at again from the idle state.
          push_token(kind_for(lex_st), tok_begin, wcol[i] - tok_begin);
          lex_st = LX_IDLE;
        end
      end else begin
        c1 = (i + 1 < m) ? wc[i + 1] : -1;
        c2 = (i + 2 < m) ? wc[i + 2] : -1;
        d  = classify_start(wc[i], c1, c2);
        case (d.act)
          SD_WAIT: begin
            tok_begin = wcol[i];
            for (j = 0; j + i < m && j < 2; j++) pend_chr[j] = wc[i + j];
            pend_cnt = j;
            i = m;
          end
          SD_SINGLE: begin
            push_token(llt_pkg::KIND_SPECIAL, wcol[i], 1);
            i++;
          end
          SD_TOKEN: begin
            lex_st    = d.st;
            tok_begin = wcol[i];
            i += d.used;
          end
          default: i++;
        endcase
      end
    end
  endfunction

  // Newline or end of input: flush the lexer, report the line length, next line.
  function automatic void close_line();
    scan_chars(0, col_cnt);
    if (col_cnt > 0) push_token(llt_pkg::KIND_EOL, 0, col_cnt);
    if (line_cnt != llt_pkg::LINE_MAX) line_cnt++;
    col_cnt   = 0;
    ovf_seen  = 1'b0;
    lex_st    = LX_IDLE;
    pend_cnt  = 0;
    tok_begin = 0;
  endfunction

  // Works out every result that one accepted input item causes.
  function automatic void tokenize_byte(logic [7:0] b, logic eoi);
    int          c;
    int unsigned col;
    step_n = 0;
    if (eoi) begin
      // The data byte is ignored; an empty line is left as it is.
      if (col_cnt != 0) close_line();
    end else if (b == 8'h0A) begin
      close_line();
    end else if (!(b < 8'h20 || b == 8'h7F || b[7:6] == 2'b10)) begin
      // UTF-8 start bytes stand in as '?'; control and continuation bytes vanish.
      c   = (b >= 8'h80) ? "?" : int'(b);
      col = col_cnt;
      if (col_cnt >= COL_TOP) begin
        col      = COL_TOP;
        ovf_seen = 1'b1;
      end else begin
        col_cnt++;
      end
      scan_chars(c, col);
    end
    if (step_n > 0) expected_tokens[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_char(logic [7:0] b);
    feed_item_t it;
    it.data  = b;
    it.eoi   = 1'b0;
    it.burst = line_burst;
    feed_q.push_back(it);
  endtask

  task automatic add_eoi(logic [7:0] b);
    feed_item_t it;
    it.data  = b;
    it.eoi   = 1'b1;
    it.burst = line_burst;
    feed_q.push_back(it);
  endtask

  task automatic add_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) add_char(s[k]);
  endtask

  localparam string DIGITS  = "0123456789";
  localparam string HEXDIG  = "0123456789abcdefABCDEF";
  localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string ROUTE   = "abcdeXYZ:./\\";
  localparam string PUNCT   = "!\"#$%&'()*,;<=>?@[]^`{|}:~-+.";

  task automatic add_digits(int lo, int hi);
    int n;
    int k;
    n = $urandom_range(lo, hi);
    for (k = 0; k < n; k++) add_char(pick(DIGITS));
  endtask

  // One token-shaped piece of a line with random content, sometimes malformed.
  task automatic add_random_token();
    int n;
    int k;
    case ($urandom_range(0, 9))
      0: add_digits(1, 4);
      1: begin
        add_text($urandom_range(0, 4) == 0 ? "0X" : "0x");
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) add_char(pick(HEXDIG));
      end
      2: begin
        add_text("0b");
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) add_char(pick("0112"));
      end
      3: begin
        if ($urandom_range(0, 3) == 0) add_text("-.");
        else begin
          add_digits(1, 3);
          if ($urandom_range(0, 2) != 0) add_char(".");
        end
        add_digits(0, 2);
        if ($urandom_range(0, 1) == 1) begin
          add_char(pick("eE"));
          if ($urandom_range(0, 1) == 1) add_char(pick("+-"));
          add_digits(0, 2);
        end
      end
      4: begin
        add_char(pick("-+."));
        add_digits(0, 3);
      end
      5: begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) add_char(pick(LETTERS));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: add_char("/");
          1: add_text("~/");
          default: begin
            add_char(pick(LETTERS));
            add_char(":");
            add_char(pick("/\\"));
          end
        endcase
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) add_char(pick(ROUTE));
      end
      7: add_char(pick(PUNCT));
      8: add_char(8'($urandom_range(0, 255)));
      default: begin
        // A letter and ':' without a slash is a word and a separate special.
        add_char(pick(LETTERS));
        add_char(":");
        add_char(pick("a1 ."));
      end
    endcase
  endtask

  // A line of random tokens with varied separators and line endings, or now and then an empty line.
  task automatic add_random_line();
    int n_tok;
    int k;
    line_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 1) add_char(8'h0A);
      else add_eoi(8'($urandom_range(0, 255)));
    end else begin
      n_tok = $urandom_range(1, 5);
      for (k = 0; k < n_tok; k++) begin
        add_random_token();
        case ($urandom_range(0, 19))
          0, 1, 2:    ;
          3, 4, 5:    add_char(pick(PUNCT));
          default:    add_char(" ");
        endcase
      end
      case ($urandom_range(0, 19))
        0, 1, 2: add_eoi(8'($urandom_range(0, 255)));
        3, 4:    add_text("\r\n");
        default: add_char(8'h0A);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents queued bytes, idles at random after each transfer except
  // after a burst byte, and hands every accepted item to the predictor.
  // ---------------------------------------------------------------------------
  int tx_wait = 0;

  always @(posedge clk or negedge rst_n) begin
    feed_item_t it;
    if (!rst_n) begin
      tx_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tokenize_byte(in_ch.data_byte, in_ch.end_of_input);
        bytes_moved++;
      end
      // While a byte is offered and not yet taken it must stay unchanged.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          tx_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          it = feed_q.pop_front();
          tx_byte  <= it.data;
          tx_eoi   <= it.eoi;
          tx_valid <= 1'b1;
          tx_wait = it.burst ? 0 : $urandom_range(0, 10);
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each transfer against the oldest expectation and
  // stalls the output at random, with occasional stretches of full speed.
  // ---------------------------------------------------------------------------
  int rx_wait = 0;
  bit rx_fast = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    llt_pkg::result_t got;
    llt_pkg::result_t want;
    if (!rst_n) begin
      rx_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_moved++;
        got.kind   = out_ch.token_kind;
        got.start  = out_ch.token_start;
        got.length = out_ch.token_length;
        got.line   = out_ch.line_number;
        got.ovf    = out_ch.column_overflow;
        got.last   = out_ch.last_of_run;
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: kind %0d start %0d len %0d line %0d",
                     got.kind, got.start, got.length, got.line);
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.start !== want.start ||
              got.length !== want.length || got.line !== want.line ||
              got.ovf !== want.ovf || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result %0d expected: kind %0d start %0d len %0d line %0d %s%0b%s%0b",
                       results_moved, want.kind, want.start, want.length, want.line,
                       "ovf ", want.ovf, " last ", want.last);
              $display("result %0d actual:   kind %0d start %0d len %0d line %0d %s%0b%s%0b",
                       results_moved, got.kind, got.start, got.length, got.line,
                       "ovf ", got.ovf, " last ", got.last);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 10);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rx_ready <= (rx_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a hung handshake ends the run as a failure.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", cyc,
             expected_tokens.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, release reset, drain and report.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int base;

    // Directed part. An end of input on an empty line and an empty line come first;
    // then one line of hex, binary, a float that starts with "-.", a home path and a
    // UTF-8 start byte, followed by dropped continuation and control bytes.
    add_eoi(8'hFF);
    add_char(8'h0A);
    add_text("0xF 0b1 -.5 ~/a");
    add_char(8'hC3);
    add_char(8'hA9);
    add_char(8'h00);
    add_char(8'h7F);
    add_char(8'h0A);
    // A pending line closed by end of input, whose data byte is ignored.
    add_text("z");
    add_eoi(8'h00);

    // Random lines, most of them well formed.
    base = feed_q.size();
    while (feed_q.size() < base + 200) add_random_line();

    // A short closing line at full speed.
    line_burst = 1'b1;
    add_text("ok 1\n");
    line_burst = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || tx_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    // Allow extra time for stray results after the expected ones.
    repeat (16) @(posedge clk);

    if (expected_tokens.size() != 0) begin
      mismatch_count += expected_tokens.size();
      $display("%0d expected results never arrived", expected_tokens.size());
    end

    $display("Checked %0d results from %0d byte transfers over %0d lines.",
             results_moved, bytes_moved, line_cnt - 1);
    $display("Stimulus mixed all token kinds and filtered bytes; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== log_line_tokenizer_core.f =====
rtl/core/llt_pkg.sv
rtl/core/llt_ifs.sv
rtl/core/llt_lexer.sv
rtl/core/llt_result_fifo.sv
rtl/core/log_line_tokenizer_core.sv
dv/tb_top.sv
